// File: hw/rtl/pipc_pkg.sv
// Shared types and constants for the point-in-polygon classifier.
`timescale 1ns / 1ps
`default_nettype none

package pipc_pkg;

    // Field widths.
    localparam int COORD_W   = 21;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int OP_W      = 2;
    localparam int LOC_W     = 2;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 8;

    // Operation codes carried in s_axis_tuser.
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

    // Location codes of a query result.
    localparam logic [LOC_W-1:0] LOC_OUTSIDE = 2'd0;
    localparam logic [LOC_W-1:0] LOC_ON_EDGE = 2'd1;
    localparam logic [LOC_W-1:0] LOC_INSIDE  = 2'd2;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [PROD_W-1:0]  prod_t;

    // One stored vertex, x in the low half.
    typedef struct packed {
        coord_t y;
        coord_t x;
    } vertex_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_FIRST,
        S_CUR,
        S_MUL1,
        S_MUL2,
        S_EVAL,
        S_RESULT
    } state_t;

endpackage

`default_nettype wire

// File: hw/rtl/point_in_polygon_classifier.sv
// Point-in-polygon classifier: vertex store, edge-walking sequencer and result register.
//
//  Channel  | Signals                        | Payload
//  ---------+--------------------------------+------------------------------------------
//  s_axis   | tvalid tready tdata[47:0] tuser| tuser: operation; tdata: point_x, point_y
//  m_axis   | tvalid tready tdata[7:0]       | tdata: location, status
//
//  Clear and append go from acceptance through the S_RESULT state to the output register.
//  A query walks the edges in turn: each edge uses the single shared
//  22 x 22 multiplier twice and is then compared in S_EVAL; an empty polygon skips the walk.
//  rst_n clears the vertex count, edge index, parity, sequencer and output valid flag.
//  s_axis_tready is high only while the sequencer is idle; a finished result
//  waits in the sequencer until the output register is free, and the output
//  register holds its transaction while m_axis_tready is low.
`timescale 1ns / 1ps
`default_nettype none

module point_in_polygon_classifier #(
    parameter int MAX_VERTICES = 256
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [20:0] point_x, [41:21] point_y, [47:42] zero
    input  wire logic [pipc_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // [1:0] operation
    input  wire logic [pipc_pkg::OP_W-1:0]       s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [1:0] location, [2] status, [7:3] zero
    output logic      [pipc_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

    localparam int AddrW = $clog2(MAX_VERTICES);
    localparam int CntW  = $clog2(MAX_VERTICES + 1);
    localparam int VertW = $bits(pipc_pkg::vertex_t);

    pipc_pkg::state_t state_reg, state_next;

    logic [CntW-1:0]           count_reg, count_next;
    logic [CntW-1:0]           edge_reg, edge_next;
    logic                      parity_reg, parity_next;
    pipc_pkg::coord_t          px_reg, px_next;
    pipc_pkg::coord_t          py_reg, py_next;
    pipc_pkg::vertex_t         first_reg, first_next;
    pipc_pkg::vertex_t         prev_reg, prev_next;
    pipc_pkg::vertex_t         cur_reg, cur_next;
    pipc_pkg::prod_t           c1_reg, c1_next;
    pipc_pkg::prod_t           c2_reg, c2_next;
    logic [pipc_pkg::LOC_W-1:0] res_loc_reg, res_loc_next;
    logic                      res_status_reg, res_status_next;
    logic                      m_valid_reg, m_valid_next;
    logic [pipc_pkg::LOC_W-1:0] m_loc_reg, m_loc_next;
    logic                      m_status_reg, m_status_next;

    logic                      accept;
    logic [pipc_pkg::OP_W-1:0] in_op;
    pipc_pkg::vertex_t         in_vertex;
    logic                      out_load;
    logic                      last_edge;
    logic                      next_from_ram;
    logic [CntW:0]             edge_p1;
    logic [CntW:0]             edge_p2;

    logic                      wr_en;
    logic [AddrW-1:0]          rd_addr;
    logic [VertW-1:0]          rd_data;
    pipc_pkg::vertex_t         rd_vertex;

    pipc_pkg::diff_t           ex, ey, dx, dy;
    pipc_pkg::diff_t           mul_a, mul_b;
    pipc_pkg::prod_t           product;

    logic                      on_x_span, on_y_span, on_segment;
    logic                      straddle, crosses;

    // Input transaction fields; point_x lands in the low half of the vertex.
    assign s_axis_tready = (state_reg == pipc_pkg::S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign in_op         = s_axis_tuser;
    assign in_vertex     = s_axis_tdata[2*pipc_pkg::COORD_W-1:0];

    // Edge bookkeeping: index of the next vertex after this edge and the one after that.
    assign edge_p1       = (CntW+1)'(edge_reg) + (CntW+1)'(1);
    assign edge_p2       = (CntW+1)'(edge_reg) + (CntW+1)'(2);
    assign last_edge     = (edge_p1 == (CntW+1)'(count_reg));
    assign next_from_ram = (edge_p2 < (CntW+1)'(count_reg));

    // Vertex store; the read address runs one step ahead while the products are formed.
    assign wr_en = accept && (in_op == pipc_pkg::OP_APPEND)
                   && (count_reg < CntW'(MAX_VERTICES));

    always_comb
    begin
        case (state_reg)
            pipc_pkg::S_IDLE: rd_addr = '0;
            pipc_pkg::S_MUL2: rd_addr = edge_p2[AddrW-1:0];
            default:          rd_addr = edge_p1[AddrW-1:0];
        endcase
    end

    pipc_ram #(
        .WIDTH (VertW),
        .DEPTH (MAX_VERTICES)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AddrW-1:0]),
        .wr_data (in_vertex),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_vertex = rd_data;

    // Edge vectors relative to the start vertex of the current edge.
    assign ex = pipc_pkg::DIFF_W'(cur_reg.x) - pipc_pkg::DIFF_W'(prev_reg.x);
    assign ey = pipc_pkg::DIFF_W'(cur_reg.y) - pipc_pkg::DIFF_W'(prev_reg.y);
    assign dx = pipc_pkg::DIFF_W'(px_reg) - pipc_pkg::DIFF_W'(prev_reg.x);
    assign dy = pipc_pkg::DIFF_W'(py_reg) - pipc_pkg::DIFF_W'(prev_reg.y);

    // Shared multiplier: ex * dy in the first product cycle, dx * ey in the second.
    assign mul_a   = (state_reg == pipc_pkg::S_MUL2) ? dx : ex;
    assign mul_b   = (state_reg == pipc_pkg::S_MUL2) ? ey : dy;
    assign product = mul_a * mul_b;

    // Edge tests on the registered products.
    assign on_x_span  = ((px_reg >= prev_reg.x) && (px_reg <= cur_reg.x))
                        || ((px_reg >= cur_reg.x) && (px_reg <= prev_reg.x));
    assign on_y_span  = ((py_reg >= prev_reg.y) && (py_reg <= cur_reg.y))
                        || ((py_reg >= cur_reg.y) && (py_reg <= prev_reg.y));
    assign on_segment = (c1_reg == c2_reg) && on_x_span && on_y_span;
    assign straddle   = (prev_reg.y > py_reg) != (cur_reg.y > py_reg);
    // For a rising edge the point is on the crossing side when ex*dy > dx*ey;
    // a falling edge flips both signs, so the compare reverses.
    assign crosses    = (cur_reg.y > prev_reg.y) ? (c1_reg > c2_reg) : (c1_reg < c2_reg);

    // Output register is loaded once it is empty or being drained.
    assign out_load = (state_reg == pipc_pkg::S_RESULT) && (!m_valid_reg || m_axis_tready);

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pipc_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if ((in_op == pipc_pkg::OP_QUERY) && (count_reg != '0))
                    begin
                        state_next = pipc_pkg::S_FIRST;
                    end
                    else
                    begin
                        state_next = pipc_pkg::S_RESULT;
                    end
                end
            end
            pipc_pkg::S_FIRST:
            begin
                state_next = pipc_pkg::S_CUR;
            end
            pipc_pkg::S_CUR:
            begin
                state_next = pipc_pkg::S_MUL1;
            end
            pipc_pkg::S_MUL1:
            begin
                state_next = pipc_pkg::S_MUL2;
            end
            pipc_pkg::S_MUL2:
            begin
                state_next = pipc_pkg::S_EVAL;
            end
            pipc_pkg::S_EVAL:
            begin
                if (on_segment || last_edge)
                begin
                    state_next = pipc_pkg::S_RESULT;
                end
                else
                begin
                    state_next = pipc_pkg::S_MUL1;
                end
            end
            pipc_pkg::S_RESULT:
            begin
                if (out_load)
                begin
                    state_next = pipc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pipc_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath and result updates for each state.
    always_comb
    begin
        count_next      = count_reg;
        edge_next       = edge_reg;
        parity_next     = parity_reg;
        px_next         = px_reg;
        py_next         = py_reg;
        first_next      = first_reg;
        prev_next       = prev_reg;
        cur_next        = cur_reg;
        c1_next         = c1_reg;
        c2_next         = c2_reg;
        res_loc_next    = res_loc_reg;
        res_status_next = res_status_reg;
        case (state_reg)
            pipc_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    px_next         = in_vertex.x;
                    py_next         = in_vertex.y;
                    edge_next       = '0;
                    parity_next     = 1'b0;
                    res_loc_next    = pipc_pkg::LOC_OUTSIDE;
                    res_status_next = 1'b0;
                    case (in_op)
                        pipc_pkg::OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        pipc_pkg::OP_APPEND:
                        begin
                            if (wr_en)
                            begin
                                count_next = count_reg + CntW'(1);
                            end
                            else
                            begin
                                res_status_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            res_loc_next = pipc_pkg::LOC_OUTSIDE;
                        end
                    endcase
                end
            end
            pipc_pkg::S_FIRST:
            begin
                first_next = rd_vertex;
                prev_next  = rd_vertex;
            end
            pipc_pkg::S_CUR:
            begin
                cur_next = (count_reg > CntW'(1)) ? rd_vertex : first_reg;
            end
            pipc_pkg::S_MUL1:
            begin
                c1_next = product;
            end
            pipc_pkg::S_MUL2:
            begin
                c2_next = product;
            end
            pipc_pkg::S_EVAL:
            begin
                if (on_segment)
                begin
                    res_loc_next = pipc_pkg::LOC_ON_EDGE;
                end
                else
                begin
                    parity_next = parity_reg ^ (straddle && crosses);
                    if (last_edge)
                    begin
                        res_loc_next = (parity_reg ^ (straddle && crosses))
                                       ? pipc_pkg::LOC_INSIDE : pipc_pkg::LOC_OUTSIDE;
                    end
                    edge_next = edge_p1[CntW-1:0];
                    prev_next = cur_reg;
                    cur_next  = next_from_ram ? rd_vertex : first_reg;
                end
            end
            default:
            begin
                res_loc_next = res_loc_reg;
            end
        endcase
    end

    // Output register.
    always_comb
    begin
        m_valid_next  = m_valid_reg && !m_axis_tready;
        m_loc_next    = m_loc_reg;
        m_status_next = m_status_reg;
        if (out_load)
        begin
            m_valid_next  = 1'b1;
            m_loc_next    = res_loc_reg;
            m_status_next = res_status_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {5'b0, m_status_reg, m_loc_reg};

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= pipc_pkg::S_IDLE;
            count_reg   <= '0;
            edge_reg    <= '0;
            parity_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            edge_reg    <= edge_next;
            parity_reg  <= parity_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        px_reg         <= px_next;
        py_reg         <= py_next;
        first_reg      <= first_next;
        prev_reg       <= prev_next;
        cur_reg        <= cur_next;
        c1_reg         <= c1_next;
        c2_reg         <= c2_next;
        res_loc_reg    <= res_loc_next;
        res_status_reg <= res_status_next;
        m_loc_reg      <= m_loc_next;
        m_status_reg   <= m_status_next;
    end

    // The vertex count never passes the store depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntW'(MAX_VERTICES))
        else $error("vertex count beyond store depth");

    // While walking edges, the edge index stays below the vertex count.
    a_edge_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pipc_pkg::S_MUL1 || state_reg == pipc_pkg::S_MUL2
         || state_reg == pipc_pkg::S_EVAL) |-> (edge_reg < count_reg))
        else $error("edge index beyond vertex count");

    // A store write, made only for an accepted append with room left, advances the vertex count.
    a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> (count_reg == $past(count_reg) + CntW'(1)))
        else $error("store write without count advance");

    // A result handed to the output register shows up as a valid transaction.
    a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (m_axis_tvalid && (state_reg == pipc_pkg::S_IDLE)))
        else $error("result not presented on output");

endmodule

`default_nettype wire

// File: hw/rtl/pipc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module pipc_ram #(
    parameter int WIDTH = 42,
    parameter int DEPTH = 256,
    localparam int AddrW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AddrW-1:0] wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AddrW-1:0] rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// File: dv/tb_point_in_polygon_classifier.sv
// Self-checking testbench for the point-in-polygon classifier.
`timescale 1ns / 1ps

module tb_point_in_polygon_classifier;

    localparam int MAX_VERTS   = 256;
    localparam int STALL_LIMIT = 5000;
    localparam int PAD_W       = pipc_pkg::S_TDATA_W - 2 * pipc_pkg::COORD_W;

    // The fourth operation code has no function: the polygon stays as it is and an outside result returns.
    localparam logic [pipc_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [pipc_pkg::LOC_W-1:0] location;
        logic                       status;
    } outcome_t;

    logic                           clk           = 1'b0;
    logic                           rst_n         = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [pipc_pkg::S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic [pipc_pkg::OP_W-1:0]      s_axis_tuser  = pipc_pkg::OP_CLEAR;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [pipc_pkg::M_TDATA_W-1:0] m_axis_tdata;

    // Shadow copy of the polygon held by the block.
    pipc_pkg::coord_t poly_x [MAX_VERTS];
    pipc_pkg::coord_t poly_y [MAX_VERTS];
    int unsigned      poly_count = 0;

    outcome_t awaited_outcomes [$];
    outcome_t oldest;
    int       error_count    = 0;
    int       items_sent     = 0;
    int       send_idle_pct  = 0;
    int       recv_stall_pct = 0;
    int       hold_request   = 0;
    int       hold_left      = 0;
    int       quiet_cycles   = 0;

    point_in_polygon_classifier #(
        .MAX_VERTICES (MAX_VERTS)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    // True when the point lies on the closed segment from a to b.
    function automatic logic on_edge(input pipc_pkg::coord_t px, input pipc_pkg::coord_t py,
                                     input pipc_pkg::coord_t ax, input pipc_pkg::coord_t ay,
                                     input pipc_pkg::coord_t bx, input pipc_pkg::coord_t by);
        pipc_pkg::diff_t ex, ey, dx, dy, fx, fy;
        pipc_pkg::prod_t cross_a, cross_b, span_x, span_y;
        ex      = bx - ax;
        ey      = by - ay;
        dx      = px - ax;
        dy      = py - ay;
        fx      = px - bx;
        fy      = py - by;
        cross_a = ex * dy;
        cross_b = dx * ey;
        span_x  = dx * fx;
        span_y  = dy * fy;
        return (cross_a == cross_b) && (span_x <= 0) && (span_y <= 0);
    endfunction

    // Crossing-number test over the stored edges, closing edge included.
    function automatic logic [pipc_pkg::LOC_W-1:0] locate_point(input pipc_pkg::coord_t px,
                                                                input pipc_pkg::coord_t py);
        int unsigned      j;
        logic             odd;
        pipc_pkg::coord_t x0, y0, x1, y1;
        pipc_pkg::diff_t  dx, dy, ex, ey;
        pipc_pkg::prod_t  lhs, rhs;
        odd = 1'b0;
        for (int unsigned i = 0; i < poly_count; i++)
        begin
            j  = (i + 1 < poly_count) ? i + 1 : 0;
            x0 = poly_x[i];
            y0 = poly_y[i];
            x1 = poly_x[j];
            y1 = poly_y[j];
            if (on_edge(px, py, x0, y0, x1, y1))
                return pipc_pkg::LOC_ON_EDGE;
            // Only edges with one end at or below the point and one above count.
            if ((y0 <= py) != (y1 <= py))
            begin
                dx = px - x0;
                dy = py - y0;
                ex = x1 - x0;
                ey = y1 - y0;
                if (ey < 0)
                begin
                    ey = -ey;
                    dy = -dy;
                end
                lhs = dy * ex;
                rhs = dx * ey;
                if (lhs > rhs)
                    odd = ~odd;
            end
        end
        return odd ? pipc_pkg::LOC_INSIDE : pipc_pkg::LOC_OUTSIDE;
    endfunction

    // Applies one operation to the shadow polygon and returns its outcome.
    function automatic outcome_t polygon_step(input logic [pipc_pkg::OP_W-1:0] op,
                                              input pipc_pkg::coord_t px,
                                              input pipc_pkg::coord_t py);
        outcome_t res;
        res = '0;
        case (op)
            pipc_pkg::OP_CLEAR:  poly_count = 0;
            pipc_pkg::OP_APPEND:
            begin
                if (poly_count < MAX_VERTS)
                begin
                    poly_x[poly_count] = px;
                    poly_y[poly_count] = py;
                    poly_count++;
                end
                else
                    res.status = 1'b1;
            end
            pipc_pkg::OP_QUERY:  res.location = locate_point(px, py);
            default:   ;
        endcase
        return res;
    endfunction

    // Offers one transaction, starting and ending at a falling edge.
    task automatic send_item(input logic [pipc_pkg::OP_W-1:0] op,
                             input pipc_pkg::coord_t px, input pipc_pkg::coord_t py);
        // Each idle cycle is drawn on its own, with the given percentage as its chance.
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tdata  = {{PAD_W{1'b0}}, py, px};
        s_axis_tuser  = op;
        s_axis_tvalid = 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        awaited_outcomes.insert(awaited_outcomes.size(), polygon_step(op, px, py));
        if (op != OP_UNUSED)
            items_sent++;
        @(negedge clk);
    endtask

    // Withdraws the input before time passes outside send_item.
    task automatic park_input();
        s_axis_tvalid = 1'b0;
    endtask

    // Empty, one-vertex and two-vertex polygons plus the unused code.
    task automatic test_degenerate_polygons();
        send_item(pipc_pkg::OP_QUERY, 0, 0);
        send_item(OP_UNUSED, 5, 5);
        send_item(pipc_pkg::OP_CLEAR, 0, 0);
        send_item(pipc_pkg::OP_QUERY, 7, -3);
        send_item(pipc_pkg::OP_APPEND, 7, -3);
        send_item(pipc_pkg::OP_QUERY, 7, -3);
        send_item(pipc_pkg::OP_QUERY, 8, -3);
        send_item(pipc_pkg::OP_APPEND, 27, 7);
        send_item(pipc_pkg::OP_QUERY, 17, 2);
        send_item(pipc_pkg::OP_QUERY, 17, 3);
        send_item(pipc_pkg::OP_QUERY, 37, 12);
    endtask

    // Square at the coordinate extremes, then a small triangle.
    task automatic test_extreme_coordinates();
        send_item(pipc_pkg::OP_CLEAR, 0, 0);
        send_item(pipc_pkg::OP_APPEND, -21'sd1048576, -21'sd1048576);
        send_item(pipc_pkg::OP_APPEND, 21'sd1048575, -21'sd1048576);
        send_item(pipc_pkg::OP_APPEND, 21'sd1048575, 21'sd1048575);
        send_item(pipc_pkg::OP_APPEND, -21'sd1048576, 21'sd1048575);
        send_item(pipc_pkg::OP_QUERY, 0, 0);
        send_item(pipc_pkg::OP_QUERY, -21'sd1048576, 0);
        send_item(pipc_pkg::OP_QUERY, 21'sd1048575, 21'sd1048575);
        send_item(pipc_pkg::OP_QUERY, 0, -21'sd1048576);
        send_item(pipc_pkg::OP_CLEAR, 0, 0);
        send_item(pipc_pkg::OP_APPEND, 0, 0);
        send_item(pipc_pkg::OP_APPEND, 100, 0);
        send_item(pipc_pkg::OP_APPEND, 0, 100);
        send_item(pipc_pkg::OP_QUERY, 60, 60);
        send_item(pipc_pkg::OP_QUERY, 50, 50);
        send_item(pipc_pkg::OP_QUERY, 10, 10);
        send_item(pipc_pkg::OP_QUERY, -1, 100);
        send_item(pipc_pkg::OP_QUERY, 200, 0);
    endtask

    // Fill the store with a square outline, overflow it, then query.
    task automatic test_vertex_store_full();
        send_item(pipc_pkg::OP_CLEAR, 0, 0);
        for (int i = 0; i < MAX_VERTS / 4; i++)
            send_item(pipc_pkg::OP_APPEND, pipc_pkg::coord_t'(i * 1000), 0);
        for (int i = 0; i < MAX_VERTS / 4; i++)
            send_item(pipc_pkg::OP_APPEND, 64000, pipc_pkg::coord_t'(i * 1000));
        for (int i = 0; i < MAX_VERTS / 4; i++)
            send_item(pipc_pkg::OP_APPEND, pipc_pkg::coord_t'(64000 - i * 1000), 64000);
        for (int i = 0; i < MAX_VERTS / 4; i++)
            send_item(pipc_pkg::OP_APPEND, 0, pipc_pkg::coord_t'(64000 - i * 1000));
        send_item(pipc_pkg::OP_APPEND, 5, 5);
        send_item(pipc_pkg::OP_APPEND, -9, 77);
        send_item(pipc_pkg::OP_QUERY, 32000, 32000);
        send_item(pipc_pkg::OP_QUERY, 500, 0);
        send_item(pipc_pkg::OP_QUERY, 70000, 0);
    endtask

    // Hold the output back long enough that the input backs up.
    task automatic test_output_holdoff();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_item(pipc_pkg::OP_CLEAR, 0, 0);
        send_item(pipc_pkg::OP_APPEND, -40, -40);
        send_item(pipc_pkg::OP_APPEND, 40, -40);
        send_item(pipc_pkg::OP_APPEND, 0, 40);
        park_input();
        @(posedge clk);
        hold_request = 300;
        @(negedge clk);
        for (int i = 0; i < 8; i++)
            send_item(pipc_pkg::OP_QUERY, pipc_pkg::coord_t'($urandom_range(0, 100) - 50),
                      pipc_pkg::coord_t'($urandom_range(0, 100) - 50));
    endtask

    // One random session: a fresh polygon and queries, or a burst of noise.
    task automatic random_session();
        int               pick, span, nverts, a, b, ax, ay, bx, by;
        pipc_pkg::coord_t cx, cy, qx, qy;
        pick = $urandom_range(0, 99);
        case ($urandom_range(0, 3))
            0:       span = 8;
            1:       span = 300;
            2:       span = 70000;
            default: span = 1048575;
        endcase
        cx = (span == 1048575) ? pipc_pkg::coord_t'(0) : pipc_pkg::coord_t'($urandom);
        cy = (span == 1048575) ? pipc_pkg::coord_t'(0) : pipc_pkg::coord_t'($urandom);
        if (pick >= 85)
        begin
            repeat ($urandom_range(1, 4))
                send_item(pipc_pkg::OP_W'($urandom_range(0, 3)),
                          pipc_pkg::coord_t'($urandom), pipc_pkg::coord_t'($urandom));
        end
        else
        begin
            if (pick < 70)
                nverts = ($urandom_range(0, 19) == 0) ? $urandom_range(11, 48)
                                                      : $urandom_range(3, 10);
            else
                nverts = $urandom_range(1, 2);
            send_item(pipc_pkg::OP_CLEAR, pipc_pkg::coord_t'($urandom),
                      pipc_pkg::coord_t'($urandom));
            repeat (nverts)
                send_item(pipc_pkg::OP_APPEND,
                          pipc_pkg::coord_t'(int'(cx) + $urandom_range(0, 2 * span) - span),
                          pipc_pkg::coord_t'(int'(cy) + $urandom_range(0, 2 * span) - span));
            repeat ($urandom_range(2, 8))
            begin
                a  = $urandom_range(0, poly_count - 1);
                b  = (a + 1 < poly_count) ? a + 1 : 0;
                ax = poly_x[a];
                ay = poly_y[a];
                bx = poly_x[b];
                by = poly_y[b];
                // Aim near vertices, edges and vertex heights to hit the ties.
                case ($urandom_range(0, 4))
                    0:
                    begin
                        qx = pipc_pkg::coord_t'(ax + $urandom_range(0, 2 * span) - span);
                        qy = pipc_pkg::coord_t'(ay + $urandom_range(0, 2 * span) - span);
                    end
                    1:
                    begin
                        qx = pipc_pkg::coord_t'(ax);
                        qy = pipc_pkg::coord_t'(ay);
                    end
                    2:
                    begin
                        qx = pipc_pkg::coord_t'((ax + bx) >>> 1);
                        qy = pipc_pkg::coord_t'((ay + by) >>> 1);
                    end
                    3:
                    begin
                        qx = pipc_pkg::coord_t'(ax + $urandom_range(0, 2 * span) - span);
                        qy = pipc_pkg::coord_t'(ay);
                    end
                    default:
                    begin
                        qx = pipc_pkg::coord_t'($urandom);
                        qy = pipc_pkg::coord_t'($urandom);
                    end
                endcase
                send_item(pipc_pkg::OP_QUERY, qx, qy);
            end
        end
    endtask

    task automatic test_random_polygons(input int send_pct, input int recv_pct,
                                        input int item_goal);
        int stop_at;
        stop_at        = items_sent + item_goal;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        while (items_sent < stop_at)
            random_session();
    endtask

    // Output ready: a requested hold-off first, otherwise random stalls.
    always @(negedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0)
        begin
            m_axis_tready = 1'b0;
            hold_left--;
        end
        else
            m_axis_tready = ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Compare every output transaction with the oldest outstanding outcome.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (awaited_outcomes.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got tdata 0x%02h",
                         $time, m_axis_tdata);
                error_count++;
            end
            else
            begin
                oldest = awaited_outcomes.pop_front();
                if (m_axis_tdata[pipc_pkg::LOC_W-1:0] !== oldest.location)
                begin
                    $display("%0t: location mismatch, expected %0d, got %0d",
                             $time, oldest.location, m_axis_tdata[pipc_pkg::LOC_W-1:0]);
                    error_count++;
                end
                if (m_axis_tdata[pipc_pkg::LOC_W] !== oldest.status)
                begin
                    $display("%0t: status mismatch, expected %0d, got %0d",
                             $time, oldest.status, m_axis_tdata[pipc_pkg::LOC_W]);
                    error_count++;
                end
                if (m_axis_tdata[pipc_pkg::M_TDATA_W-1:pipc_pkg::LOC_W+1] !== '0)
                begin
                    $display("%0t: padding mismatch, expected 0, got 0x%0h",
                             $time, m_axis_tdata[pipc_pkg::M_TDATA_W-1:pipc_pkg::LOC_W+1]);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles in which neither side completes a transaction.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Test sequence.
    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_degenerate_polygons();
        test_extreme_coordinates();
        test_vertex_store_full();
        test_output_holdoff();
        test_random_polygons(0, 0, 140);
        test_random_polygons(54, 0, 140);
        test_random_polygons(0, 54, 140);
        test_random_polygons(11, 11, 140);
        park_input();

        wait (awaited_outcomes.size() == 0);
        repeat (3 * MAX_VERTS + 8) @(posedge clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/pipc_pkg.sv
hw/rtl/pipc_ram.sv
hw/rtl/point_in_polygon_classifier.sv
dv/tb_point_in_polygon_classifier.sv
